@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL.
// Needs signals named clk and rst_n in the scope of use; NO_ASSERTIONS removes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled in reset
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLY(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

@@ sv/nca_pkg.sv @@
// Package for the nearest centroid assign block: constants and the command code.
// No dependencies.
`default_nettype none

package nca_pkg;

    localparam int MAX_CLUSTERS_DEF = 16;
    localparam int COORD_BITS_DEF   = 14;
    localparam int NUM_CL_W         = 5;   // width of the num_clusters register
    localparam int CL_IDX_W         = 4;   // width of cluster_index
    localparam int LANE_STAGES      = 3;   // abs diff, square, sum

    typedef enum logic {
        CMD_LOAD     = 1'b0,
        CMD_CLASSIFY = 1'b1
    } cmd_t;

endpackage

`default_nettype wire

@@ sv/nca_lane.sv @@
// One distance lane: |dx|,|dy| -> squares -> squared distance, three register stages.
// Depends on nca_pkg.
`default_nettype none

module nca_lane
    import nca_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                    clk,
    input  wire logic [LANE_STAGES-1:0]  en,
    input  wire logic [COORD_BITS-1:0]   px,
    input  wire logic [COORD_BITS-1:0]   py,
    input  wire logic [COORD_BITS-1:0]   cx,
    input  wire logic [COORD_BITS-1:0]   cy,
    input  wire logic                    active,
    output logic                         dist_act,
    output logic [2*COORD_BITS:0]        sq_dist
);

    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int DIST_W = 2 * COORD_BITS + 1;

    logic [COORD_BITS-1:0] dx_reg, dy_reg, dx_next, dy_next;
    logic [SQ_W-1:0]       sqx_reg, sqy_reg, sqx_next, sqy_next;
    logic [DIST_W-1:0]     dist_reg, dist_next;
    logic                  act_reg;

    always_comb
    begin
        dx_next   = (cx >= px) ? (cx - px) : (px - cx);
        dy_next   = (cy >= py) ? (cy - py) : (py - cy);
        sqx_next  = SQ_W'(dx_reg) * SQ_W'(dx_reg);
        sqy_next  = SQ_W'(dy_reg) * SQ_W'(dy_reg);
        dist_next = DIST_W'(sqx_reg) + DIST_W'(sqy_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
        if (en[1])
        begin
            sqx_reg <= sqx_next;
            sqy_reg <= sqy_next;
        end
        if (en[2])
        begin
            dist_reg <= dist_next;
            act_reg  <= active;
        end
    end

    assign sq_dist  = dist_reg;
    assign dist_act = act_reg;

endmodule

`default_nettype wire

@@ sv/nca_min_tree.sv @@
// Registered minimum tree over the lane distances, one level per stage, plus output register.
// Ties keep the left (lower index) side. Depends on nca_pkg.
`default_nettype none

module nca_min_tree
    import nca_pkg::*;
#(
    parameter int LANES  = 16,
    parameter int DIST_W = 2 * COORD_BITS_DEF + 1
) (
    input  wire logic                        clk,
    input  wire logic [$clog2(LANES):0]      en,
    input  wire logic                        leaf_act  [LANES],
    input  wire logic [DIST_W-1:0]           leaf_dist [LANES],
    output logic [CL_IDX_W-1:0]              cluster_index
);

    localparam int LEVELS = $clog2(LANES);
    localparam int IDX_W  = LEVELS;

    // heap numbering: root is node 1, children of n are 2n and 2n+1
    logic              node_act_reg  [1:LANES-1];
    logic [DIST_W-1:0] node_dist_reg [1:LANES-1];
    logic [IDX_W-1:0]  node_idx_reg  [1:LANES-1];
    logic [CL_IDX_W-1:0] cluster_reg;

    for (genvar n = 1; n < LANES; n++)
    begin : g_node
        localparam int DEPTH = $clog2(n + 1) - 1;
        localparam int LVL   = LEVELS - 1 - DEPTH;

        logic              a_act, b_act, pick_b;
        logic [DIST_W-1:0] a_dist, b_dist;
        logic [IDX_W-1:0]  a_idx, b_idx;

        if (2 * n >= LANES)
        begin : g_leaf
            assign a_act  = leaf_act[2*n-LANES];
            assign a_dist = leaf_dist[2*n-LANES];
            assign a_idx  = IDX_W'(2*n-LANES);
            assign b_act  = leaf_act[2*n+1-LANES];
            assign b_dist = leaf_dist[2*n+1-LANES];
            assign b_idx  = IDX_W'(2*n+1-LANES);
        end
        else
        begin : g_inner
            assign a_act  = node_act_reg[2*n];
            assign a_dist = node_dist_reg[2*n];
            assign a_idx  = node_idx_reg[2*n];
            assign b_act  = node_act_reg[2*n+1];
            assign b_dist = node_dist_reg[2*n+1];
            assign b_idx  = node_idx_reg[2*n+1];
        end

        // right side wins only when strictly closer
        assign pick_b = b_act && (!a_act || (b_dist < a_dist));

        always_ff @(posedge clk)
        begin
            if (en[LVL])
            begin
                node_act_reg[n]  <= a_act || b_act;
                node_dist_reg[n] <= pick_b ? b_dist : a_dist;
                node_idx_reg[n]  <= pick_b ? b_idx : a_idx;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[LEVELS])
        begin
            cluster_reg <= node_act_reg[1] ? CL_IDX_W'(node_idx_reg[1]) : '0;
        end
    end

    assign cluster_index = cluster_reg;

endmodule

`default_nettype wire

@@ sv/nearest_centroid_assign.sv @@
// Nearest centroid assign: k-means assignment step over a table of 2-D centroids.
// Input channel (item_valid/item_stall) carries command, centroid_index, coord_x, coord_y.
// A load beat writes the centroid into its slot at the accepting edge and gives no result.
// A classify beat gives one result beat (result_valid/result_stall) with cluster_index,
// the nearest of the first num_clusters centroids by squared distance, lowest index on ties.
// num_clusters is written through num_clusters_we/num_clusters_data; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// Pipeline: input register, three distance stages per lane (all lanes in parallel),
// log2(lanes) min-tree levels, output register: 5 + log2(lanes) stages, 9 at 16 clusters.
// Throughput: one beat per cycle on both channels while result_stall is low.
// result_stall holds each occupied stage with no empty stage after it; earlier stages keep
// moving, and item_stall rises only once the input register holds a beat that cannot move on.
// Reset (rst_n, async, active low) empties the pipeline and sets num_clusters to 1;
// the centroid table is not cleared and must be loaded before it is searched.
// Depends on nca_pkg, nca_lane, nca_min_tree and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module nearest_centroid_assign
    import nca_pkg::*;
#(
    parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF,
    parameter int COORD_BITS   = COORD_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   num_clusters_we,
    input  wire logic [NUM_CL_W-1:0]    num_clusters_data,
    input  wire logic                   item_valid,
    output logic                        item_stall,
    input  wire logic                   command,
    input  wire logic [3:0]             centroid_index,
    input  wire logic [COORD_BITS-1:0]  coord_x,
    input  wire logic [COORD_BITS-1:0]  coord_y,
    output logic                        result_valid,
    input  wire logic                   result_stall,
    output logic [CL_IDX_W-1:0]         cluster_index
);

    localparam int LANES  = (MAX_CLUSTERS < 2) ? 2 : (2 ** $clog2(MAX_CLUSTERS));
    localparam int LEVELS = $clog2(LANES);
    localparam int DIST_W = 2 * COORD_BITS + 1;
    localparam int NS     = 1 + LANE_STAGES + LEVELS + 1;

    logic [NUM_CL_W-1:0]   num_clusters_reg;
    logic [NS-1:0]         v_reg, v_next;
    logic [NS-1:0]         en;
    logic                  item_acc;
    logic                  load_acc;
    logic [COORD_BITS-1:0] px_reg, py_reg;
    logic [COORD_BITS-1:0] x_tab_reg [MAX_CLUSTERS];
    logic [COORD_BITS-1:0] y_tab_reg [MAX_CLUSTERS];
    logic                  lane_act  [LANES];
    logic [DIST_W-1:0]     lane_dist [LANES];

    // stage k may load when empty or when stage k+1 loads
    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || !result_stall;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign item_stall = !en[0];
    assign item_acc   = item_valid && en[0];
    assign load_acc   = item_acc && (cmd_t'(command) == CMD_LOAD);

    always_comb
    begin
        v_next = v_reg;
        if (en[0])
        begin
            v_next[0] = item_valid && (cmd_t'(command) == CMD_CLASSIFY);
        end
        for (int k = 1; k < NS; k++)
        begin
            if (en[k])
            begin
                v_next[k] = v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg            <= '0;
            num_clusters_reg <= NUM_CL_W'(1);
        end
        else
        begin
            v_reg <= v_next;
            if (num_clusters_we)
            begin
                num_clusters_reg <= num_clusters_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            px_reg <= coord_x;
            py_reg <= coord_y;
        end
    end

    // a point in the input register reads the table before a load accepted at the
    // same edge lands, since it always moves on at that edge
    for (genvar i = 0; i < MAX_CLUSTERS; i++)
    begin : g_tab
        always_ff @(posedge clk)
        begin
            if (load_acc && (32'(centroid_index) == 32'(i)))
            begin
                x_tab_reg[i] <= coord_x;
                y_tab_reg[i] <= coord_y;
            end
        end
    end

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        logic [COORD_BITS-1:0] cx, cy;
        logic                  active;

        if (i < MAX_CLUSTERS)
        begin : g_real
            assign cx     = x_tab_reg[i];
            assign cy     = y_tab_reg[i];
            assign active = 32'(num_clusters_reg) > 32'(i);
        end
        else
        begin : g_pad
            assign cx     = '0;
            assign cy     = '0;
            assign active = 1'b0;
        end

        nca_lane #(
            .COORD_BITS (COORD_BITS)
        ) u_lane (
            .clk      (clk),
            .en       (en[LANE_STAGES:1]),
            .px       (px_reg),
            .py       (py_reg),
            .cx       (cx),
            .cy       (cy),
            .active   (active),
            .dist_act (lane_act[i]),
            .sq_dist  (lane_dist[i])
        );
    end

    nca_min_tree #(
        .LANES  (LANES),
        .DIST_W (DIST_W)
    ) u_tree (
        .clk           (clk),
        .en            (en[NS-1:LANE_STAGES+1]),
        .leaf_act      (lane_act),
        .leaf_dist     (lane_dist),
        .cluster_index (cluster_index)
    );

    assign result_valid = v_reg[NS-1];

    `ASSERT_NEXT(a_load_no_slot, load_acc, !v_reg[0], "load beat took a pipeline slot")
    `ASSERT_IMPLY(a_stall_full, item_stall, v_reg[0] && result_valid && result_stall, "input stalled with room in the pipeline")
    `ASSERT_IMPLY(a_index_range, result_valid, 32'(cluster_index) < 32'(MAX_CLUSTERS) || MAX_CLUSTERS > 16, "cluster index beyond table")

endmodule

`default_nettype wire
